[hw/rtl/pptd_pkg.sv]
// Package: shared types, constants and codes of the task dispatcher.
`timescale 1ns / 1ps
package pptd_pkg;
    localparam int SLOTS_DEF  = 16;
    localparam int PRIO_DEF   = 5;

    localparam logic [3:0] FN_REG_PER  = 4'd0;
    localparam logic [3:0] FN_REG_EVT  = 4'd1;
    localparam logic [3:0] FN_SUSPEND  = 4'd2;
    localparam logic [3:0] FN_RESUME   = 4'd3;
    localparam logic [3:0] FN_RAISE    = 4'd4;
    localparam logic [3:0] FN_DISPATCH = 4'd5;
    localparam logic [3:0] FN_DONE     = 4'd6;
    localparam logic [3:0] FN_QUERY    = 4'd7;
    localparam logic [3:0] FN_CLEAR    = 4'd8;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_BAD  = 2'd2;
    localparam logic [1:0] ST_NONE = 2'd3;

    localparam logic [1:0] CFG_STATS = 2'd0;
    localparam logic [1:0] CFG_OVR   = 2'd1;
    localparam logic [1:0] CFG_RATE  = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE, S_MUL, S_DIV_EXEC, S_DIV_PER, S_DONE_UPD, S_SCAN, S_FLUSH, S_RESP
    } state_t;

    // Divider interface
    typedef struct packed {
        logic        go;
        logic [31:0] dividend;
        logic [7:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] quotient;
    } div_rsp_t;
endpackage

[hw/rtl/pptd_div.sv]
// Radix-2 restoring divider, 32-bit dividend by 8-bit divisor, one bit per cycle.
`timescale 1ns / 1ps
module pptd_div (
    input  logic              clk,
    input  logic              rst_n,
    input  pptd_pkg::div_req_t req,
    output pptd_pkg::div_rsp_t rsp
);
    import pptd_pkg::*;

    logic        busy_reg, busy_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [31:0] q_reg, q_next;
    logic [8:0]  rem_reg, rem_next;
    logic [7:0]  dv_reg, dv_next;
    logic        done_reg, done_next;
    logic [8:0]  trial;

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        rem_next  = rem_reg;
        dv_next   = dv_reg;
        done_next = 1'b0;
        trial     = {rem_reg[7:0], q_reg[31]};
        if (req.go)
        begin
            busy_next = 1'b1;
            cnt_next  = 6'd0;
            q_next    = req.dividend;
            rem_next  = 9'd0;
            dv_next   = req.divisor;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dv_reg})
            begin
                rem_next = trial - {1'b0, dv_reg};
                q_next   = {q_reg[30:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                q_next   = {q_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd31)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 6'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
        dv_reg  <= dv_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = q_reg;

    busy_done: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg) else $error("divider done while busy");
    go_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req.go |=> busy_reg) else $error("divider did not start");
    cnt_idle: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> cnt_reg <= 6'd31) else $error("divider count overflow");
endmodule

[hw/rtl/priority_periodic_task_dispatcher_unit.sv]
// Top level: task table, sequencer and shared divider of the task dispatcher.
//
// Use: drive func and its operands with start high while busy is low; that
// beat is taken. Each result beat shows on status, slot_out, last_item and
// the statistics ports with result_valid high for one cycle; last_item marks
// the final beat of an item. The receiver cannot stall results.
// Configuration (cfg_we, cfg_index, cfg_data) is to be written while idle;
// the block itself does not enforce this. Registration, suspend, resume,
// raise, query and clear pass through S_RESP alone and show their beat
// from the result register after it; a granted periodic registration
// passes S_MUL first. A done report for a registered slot runs two passes
// of the bit-serial divider (S_DIV_EXEC, S_DIV_PER), then S_DONE_UPD and
// S_RESP. A dispatch walks the registered slots once per priority level,
// one slot per cycle. A hit is issued when the next one is found, the
// final one right after the walk; S_RESP follows when nothing is due, and
// S_FLUSH when the last step of the walk hits behind an earlier hit.
// Reset clears the table, the statistics and the configuration to its
// defaults; period, deadline and limit entries are undefined until a slot
// is registered. One item at a time: busy stays high until the last beat.
`timescale 1ns / 1ps
module priority_periodic_task_dispatcher_unit #(
    parameter int SLOTS           = pptd_pkg::SLOTS_DEF,
    parameter int PRIORITY_LEVELS = pptd_pkg::PRIO_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [3:0]  func,
    input  logic [3:0]  slot_index,
    input  logic [2:0]  task_priority,
    input  logic [23:0] task_period,
    input  logic [31:0] exec_limit,
    input  logic [31:0] time_now,
    input  logic [31:0] run_start,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    output logic        result_valid,
    output logic [1:0]  status,
    output logic [3:0]  slot_out,
    output logic        last_item,
    output logic [31:0] run_count,
    output logic [31:0] last_exec_us,
    output logic [31:0] peak_exec_us,
    output logic [31:0] overrun_total,
    output logic [31:0] missed_total
);
    import pptd_pkg::*;

    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);
    localparam int PW = (PRIORITY_LEVELS > 1) ? $clog2(PRIORITY_LEVELS) : 1;

    // config
    logic       stats_en_reg, ovr_en_reg;
    logic [7:0] cpu_reg;
    logic [7:0] rate;
    assign rate = (cpu_reg == 8'd0) ? 8'd1 : cpu_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stats_en_reg <= 1'b1;
            ovr_en_reg   <= 1'b1;
            cpu_reg      <= 8'd168;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_STATS: stats_en_reg <= cfg_data[0];
                CFG_OVR:   ovr_en_reg   <= cfg_data[0];
                CFG_RATE:  cpu_reg      <= cfg_data;
                default:   ;
            endcase
        end
    end

    // slot flags in flops
    logic [CW-1:0]     used_reg;
    logic [SLOTS-1:0]  act_reg, per_reg, sus_reg, evt_reg;
    logic [PW-1:0]     pri_reg [SLOTS];
    logic [31:0]       period_mem [SLOTS];
    logic [31:0]       dl_mem [SLOTS];
    logic [31:0]       lim_mem [SLOTS];
    logic [31:0]       st_cnt [SLOTS];
    logic [31:0]       st_last [SLOTS];
    logic [31:0]       st_peak [SLOTS];
    logic [31:0]       st_over [SLOTS];
    logic [31:0]       st_miss [SLOTS];

    // latched item
    logic [3:0]  fn_reg;
    logic [SW-1:0] sl_reg;
    logic        sl_ok_reg;
    logic [PW-1:0] pr_reg;
    logic [23:0] per_us_reg;
    logic [31:0] now_reg, st_reg;

    state_t state_reg, state_next;
    logic [PW-1:0] scan_p_reg;
    logic [SW-1:0] scan_i_reg;
    logic          found_reg;
    logic [31:0]   us_reg;
    logic [31:0]   rd_per, rd_lim;

    div_req_t dreq;
    div_rsp_t drsp;
    pptd_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

    // table reads for the addressed slot
    always_ff @(posedge clk)
    begin
        rd_per <= period_mem[sl_reg];
        rd_lim <= lim_mem[sl_reg];
    end

    logic accept;
    assign accept = start && (state_reg == S_IDLE);
    assign busy = (state_reg != S_IDLE);

    logic [31:0] elapsed;
    assign elapsed = now_reg - st_reg;

    logic scan_last_slot, scan_last_pri, scan_hit;
    logic [31:0] scan_diff;
    assign scan_last_slot = ({{(CW-SW){1'b0}}, scan_i_reg} + 1'b1 >= used_reg)
                            || (scan_i_reg == SW'(SLOTS - 1));
    assign scan_last_pri  = (scan_p_reg == PW'(PRIORITY_LEVELS - 1));
    assign scan_diff = now_reg - dl_mem[scan_i_reg];
    assign scan_hit = ({{(CW-SW){1'b0}}, scan_i_reg} < used_reg)
                      && act_reg[scan_i_reg] && !sus_reg[scan_i_reg]
                      && (pri_reg[scan_i_reg] == scan_p_reg)
                      && (per_reg[scan_i_reg] ? !scan_diff[31] : evt_reg[scan_i_reg]);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
                if (accept)
                begin
                    priority if (func == FN_REG_PER && task_period != 24'd0
                                 && used_reg < CW'(SLOTS))
                        state_next = S_MUL;
                    else if (func == FN_DISPATCH)
                        state_next = (used_reg == '0) ? S_RESP : S_SCAN;
                    else if (func == FN_DONE && {{(CW-4){1'b0}}, slot_index} < used_reg
                             && 32'(slot_index) < 32'(SLOTS))
                        state_next = S_DIV_EXEC;
                    else
                        state_next = S_RESP;
                end
            S_MUL:      state_next = S_RESP;
            S_DIV_EXEC: if (drsp.done) state_next = S_DIV_PER;
            S_DIV_PER:  if (drsp.done) state_next = S_DONE_UPD;
            S_DONE_UPD: state_next = S_RESP;
            S_SCAN:
                if (scan_last_slot && scan_last_pri)
                begin
                    priority if (scan_hit && pend_reg)
                        state_next = S_FLUSH;
                    else if (found_reg || scan_hit)
                        state_next = S_IDLE;
                    else
                        state_next = S_RESP;
                end
            S_FLUSH:    state_next = S_IDLE;
            S_RESP:     state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    // divider starts: go is registered and rises together with the entry into each divide state
    logic div_go_reg;
    always_comb
    begin
        dreq.go       = div_go_reg;
        dreq.divisor  = rate;
        dreq.dividend = (state_reg == S_DIV_PER) ? rd_per : elapsed;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            div_go_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            div_go_reg <= (state_reg == S_IDLE && state_next == S_DIV_EXEC)
                       || (state_reg == S_DIV_EXEC && drsp.done);
        end
    end

    // outputs
    logic [1:0]  o_status;
    logic [3:0]  o_slot;
    logic        o_valid, o_last, o_q;
    always_comb
    begin
        o_valid  = 1'b0;
        o_status = ST_OK;
        o_slot   = 4'd0;
        o_last   = 1'b1;
        o_q      = 1'b0;
        if (state_reg == S_SCAN)
        begin
            o_valid = scan_hit;
            o_slot  = 4'(scan_i_reg);
            o_last  = 1'b0;
        end
        else if (state_reg == S_RESP)
        begin
            o_valid = 1'b1;
            priority if (fn_reg == FN_REG_PER || fn_reg == FN_REG_EVT)
            begin
                if (fn_reg == FN_REG_PER && per_us_reg == 24'd0)
                    o_status = ST_BAD;
                else if (!sl_ok_reg)
                    o_status = ST_FULL;
                else
                    o_slot = 4'(sl_reg);
            end
            else if (fn_reg == FN_DISPATCH)
                o_status = ST_NONE;
            else if (fn_reg == FN_CLEAR)
                o_status = ST_OK;
            else if (fn_reg > FN_CLEAR || !sl_ok_reg)
                o_status = ST_BAD;
            else
            begin
                o_slot = 4'(sl_reg);
                o_q    = (fn_reg == FN_QUERY);
            end
        end
    end

    // the last dispatched beat is known only at the end of the walk, so each
    // hit is held until the next hit and the final one is issued with last set
    // when the walk ends; a last-step hit behind a held one goes out in S_FLUSH
    logic        pend_reg;
    logic [3:0]  pend_slot_reg;
    logic        rv_reg, rl_reg, rq_reg;
    logic [1:0]  rs_reg;
    logic [3:0]  rsl_reg;
    logic [SW-1:0] rqs_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rv_reg   <= 1'b0;
            pend_reg <= 1'b0;
        end
        else
        begin
            rv_reg <= 1'b0;
            if (state_reg == S_SCAN)
            begin
                if (scan_hit)
                begin
                    pend_reg      <= 1'b1;
                    pend_slot_reg <= o_slot;
                    if (pend_reg)
                    begin
                        rv_reg  <= 1'b1;
                        rl_reg  <= 1'b0;
                        rs_reg  <= ST_OK;
                        rsl_reg <= pend_slot_reg;
                        rq_reg  <= 1'b0;
                    end
                end
                if (scan_last_slot && scan_last_pri && (pend_reg || scan_hit)
                    && !(pend_reg && scan_hit))
                begin
                    pend_reg <= 1'b0;
                    rv_reg   <= 1'b1;
                    rl_reg   <= 1'b1;
                    rs_reg   <= ST_OK;
                    rsl_reg  <= scan_hit ? o_slot : pend_slot_reg;
                    rq_reg   <= 1'b0;
                end
            end
            else if (state_reg == S_FLUSH)
            begin
                pend_reg <= 1'b0;
                rv_reg   <= 1'b1;
                rl_reg   <= 1'b1;
                rs_reg   <= ST_OK;
                rsl_reg  <= pend_slot_reg;
                rq_reg   <= 1'b0;
            end
            else if (o_valid)
            begin
                rv_reg  <= 1'b1;
                rl_reg  <= o_last;
                rs_reg  <= o_status;
                rsl_reg <= o_slot;
                rq_reg  <= o_q;
                rqs_reg <= sl_reg;
            end
        end
    end

    assign result_valid  = rv_reg;
    assign status        = rs_reg;
    assign slot_out      = rsl_reg;
    assign last_item     = rl_reg;
    assign run_count     = rq_reg ? st_cnt[rqs_reg]  : 32'd0;
    assign last_exec_us  = rq_reg ? st_last[rqs_reg] : 32'd0;
    assign peak_exec_us  = rq_reg ? st_peak[rqs_reg] : 32'd0;
    assign overrun_total = rq_reg ? st_over[rqs_reg] : 32'd0;
    assign missed_total  = rq_reg ? st_miss[rqs_reg] : 32'd0;

    // datapath and table updates
    logic [31:0] new_dl;
    logic [31:0] ovr_inc;
    always_comb
    begin
        new_dl  = now_reg + rd_per;
        ovr_inc = 32'(ovr_en_reg && rd_lim != 32'd0 && us_reg > rd_lim)
                + 32'(per_reg[sl_reg] && us_reg > drsp.quotient);
    end

    logic [31:0] pc_calc;
    logic [31:0] pc_fix;
    assign pc_calc = per_us_reg * rate;
    assign pc_fix  = (pc_calc == 32'd0) ? 32'd1 : pc_calc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= '0;
            act_reg  <= '0;
            per_reg  <= '0;
            sus_reg  <= '0;
            evt_reg  <= '0;
            for (int k = 0; k < SLOTS; k++)
            begin
                pri_reg[k] <= '0;
                st_cnt[k]  <= '0;
                st_last[k] <= '0;
                st_peak[k] <= '0;
                st_over[k] <= '0;
                st_miss[k] <= '0;
            end
            scan_p_reg <= '0;
            scan_i_reg <= '0;
            found_reg  <= 1'b0;
            sl_ok_reg  <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                scan_p_reg <= '0;
                scan_i_reg <= '0;
                found_reg  <= 1'b0;
                // for a registration this flag marks a granted slot
                sl_ok_reg  <= (func == FN_REG_PER || func == FN_REG_EVT) ? 1'b0
                              : (({{(CW-4){1'b0}}, slot_index} < used_reg)
                                 && (32'(slot_index) < 32'(SLOTS)));
                if ((func == FN_REG_PER || func == FN_REG_EVT)
                    && !(func == FN_REG_PER && task_period == 24'd0)
                    && used_reg < CW'(SLOTS))
                begin
                    sl_ok_reg <= 1'b1;
                    act_reg[used_reg[SW-1:0]] <= 1'b1;
                    per_reg[used_reg[SW-1:0]] <= (func == FN_REG_PER);
                    sus_reg[used_reg[SW-1:0]] <= 1'b0;
                    evt_reg[used_reg[SW-1:0]] <= 1'b0;
                    pri_reg[used_reg[SW-1:0]] <=
                        (32'(task_priority) > 32'(PRIORITY_LEVELS - 1))
                        ? PW'(PRIORITY_LEVELS - 1) : PW'(task_priority);
                    st_cnt[used_reg[SW-1:0]]  <= '0;
                    st_last[used_reg[SW-1:0]] <= '0;
                    st_peak[used_reg[SW-1:0]] <= '0;
                    st_over[used_reg[SW-1:0]] <= '0;
                    st_miss[used_reg[SW-1:0]] <= '0;
                    used_reg <= used_reg + 1'b1;
                end
                else if (func == FN_CLEAR)
                begin
                    for (int k = 0; k < SLOTS; k++)
                    begin
                        st_cnt[k]  <= '0;
                        st_last[k] <= '0;
                        st_peak[k] <= '0;
                        st_over[k] <= '0;
                        st_miss[k] <= '0;
                    end
                end
                else if ({{(CW-4){1'b0}}, slot_index} < used_reg
                         && 32'(slot_index) < 32'(SLOTS))
                begin
                    unique case (func)
                        FN_SUSPEND: sus_reg[SW'(slot_index)] <= 1'b1;
                        FN_RESUME:  sus_reg[SW'(slot_index)] <= 1'b0;
                        FN_RAISE:
                            if (!per_reg[SW'(slot_index)])
                                evt_reg[SW'(slot_index)] <= 1'b1;
                        default: ;
                    endcase
                end
            end
            if (state_reg == S_SCAN)
            begin
                if (scan_hit)
                    found_reg <= 1'b1;
                if (scan_last_slot)
                begin
                    scan_i_reg <= '0;
                    scan_p_reg <= scan_p_reg + 1'b1;
                end
                else
                    scan_i_reg <= scan_i_reg + 1'b1;
            end
            if (state_reg == S_DONE_UPD)
            begin
                if (stats_en_reg)
                begin
                    st_cnt[sl_reg]  <= st_cnt[sl_reg] + 32'd1;
                    st_last[sl_reg] <= us_reg;
                    if (us_reg > st_peak[sl_reg])
                        st_peak[sl_reg] <= us_reg;
                    st_over[sl_reg] <= st_over[sl_reg] + ovr_inc;
                    if (per_reg[sl_reg] && !(now_reg - new_dl >= 32'h8000_0000))
                        st_miss[sl_reg] <= st_miss[sl_reg] + 32'd1;
                end
                if (!per_reg[sl_reg])
                    evt_reg[sl_reg] <= 1'b0;
            end
        end
    end

    // item latch and payload tables
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            fn_reg     <= func;
            sl_reg     <= (func == FN_REG_PER || func == FN_REG_EVT)
                          ? used_reg[SW-1:0] : SW'(slot_index);
            per_us_reg <= task_period;
            now_reg    <= time_now;
            st_reg     <= run_start;
            if ((func == FN_REG_PER || func == FN_REG_EVT) && used_reg < CW'(SLOTS)
                && !(func == FN_REG_PER && task_period == 24'd0))
                lim_mem[used_reg[SW-1:0]] <= exec_limit;
            if (func == FN_RESUME && {{(CW-4){1'b0}}, slot_index} < used_reg
                && 32'(slot_index) < 32'(SLOTS) && per_reg[SW'(slot_index)])
                dl_mem[SW'(slot_index)] <= time_now + period_mem[SW'(slot_index)];
        end
        if (state_reg == S_MUL)
        begin
            period_mem[sl_reg] <= pc_fix;
            dl_mem[sl_reg]     <= now_reg + pc_fix;
        end
        if (state_reg == S_DIV_EXEC && drsp.done)
            us_reg <= drsp.quotient;
        if (state_reg == S_DONE_UPD && per_reg[sl_reg])
            dl_mem[sl_reg] <= new_dl;
    end

    unused_pr: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= CW'(SLOTS)) else $error("slot count beyond table");
    res_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (rv_reg && rl_reg) |-> !(state_reg == S_SCAN)) else $error("beat after last");
    start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy) else $error("item not taken");
endmodule

[bench/tb.sv]
// Testbench for the priority periodic task dispatcher: directed and random items, scoreboarded.
`timescale 1ns / 1ps
module tb;
    import pptd_pkg::*;

    localparam int NSLOT   = 16;
    localparam int NPRIO   = 5;
    localparam int SETTLE  = 120;
    localparam int LIMIT   = 400000;

    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  slot;
        logic        last;
        logic [31:0] runs;
        logic [31:0] last_us;
        logic [31:0] peak_us;
        logic [31:0] overruns;
        logic [31:0] missed;
    } beat_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [3:0]  func;
    logic [3:0]  slot_index;
    logic [2:0]  task_priority;
    logic [23:0] task_period;
    logic [31:0] exec_limit;
    logic [31:0] time_now;
    logic [31:0] run_start;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [7:0]  cfg_data;
    logic        result_valid;
    logic [1:0]  status;
    logic [3:0]  slot_out;
    logic        last_item;
    logic [31:0] run_count;
    logic [31:0] last_exec_us;
    logic [31:0] peak_exec_us;
    logic [31:0] overrun_total;
    logic [31:0] missed_total;

    priority_periodic_task_dispatcher_unit i_dut (.*);

    // shadow copy of the task table
    logic        stats_on;
    logic        ovr_on;
    logic [7:0]  cyc_per_us;
    int          used;
    logic [7:0]  flags    [NSLOT];
    logic [31:0] period_c [NSLOT];
    logic [31:0] deadline [NSLOT];
    logic [31:0] limit_us [NSLOT];
    logic [31:0] st_runs  [NSLOT];
    logic [31:0] st_last  [NSLOT];
    logic [31:0] st_peak  [NSLOT];
    logic [31:0] st_over  [NSLOT];
    logic [31:0] st_miss  [NSLOT];

    beat_t       pending_beats [$];
    int          errors;
    int          cycles;
    int          gap_pct;
    logic [31:0] clock_now;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("[priority_periodic_task_dispatcher_unit] ERROR");
            $finish;
        end
    end

    task automatic report_mismatch(input string what);
        $display("mismatch @%0t: %s", $realtime, what);
        errors++;
    endtask

    always @(posedge clk) begin
        beat_t got;
        beat_t want;
        if (rst_n && result_valid) begin
            got = {status, slot_out, last_item, run_count, last_exec_us, peak_exec_us,
                   overrun_total, missed_total};
            if (pending_beats.size() == 0) begin
                report_mismatch($sformatf("unexpected beat %h", got));
            end
            else begin
                want = pending_beats.pop_front();
                if (got.status !== want.status)
                    report_mismatch($sformatf("status %0d exp %0d", got.status, want.status));
                if (got.slot !== want.slot)
                    report_mismatch($sformatf("slot_out %0d exp %0d", got.slot, want.slot));
                if (got.last !== want.last)
                    report_mismatch($sformatf("last_item %b exp %b", got.last, want.last));
                if (got.runs !== want.runs)
                    report_mismatch($sformatf("run_count %h exp %h", got.runs, want.runs));
                if (got.last_us !== want.last_us)
                    report_mismatch($sformatf("last_exec %h exp %h", got.last_us, want.last_us));
                if (got.peak_us !== want.peak_us)
                    report_mismatch($sformatf("peak_exec %h exp %h", got.peak_us, want.peak_us));
                if (got.overruns !== want.overruns)
                    report_mismatch($sformatf("overrun %h exp %h", got.overruns, want.overruns));
                if (got.missed !== want.missed)
                    report_mismatch($sformatf("missed %h exp %h", got.missed, want.missed));
            end
        end
    end

    function automatic logic [31:0] eff_rate();
        return (cyc_per_us == 8'd0) ? 32'd1 : {24'd0, cyc_per_us};
    endfunction

    function automatic beat_t mk(logic [1:0] st, logic [3:0] sl, logic lst);
        beat_t b;
        b = '0;
        b.status = st;
        b.slot   = sl;
        b.last   = lst;
        return b;
    endfunction

    function automatic bit slot_due(int i, logic [31:0] now);
        logic [31:0] diff;
        if (!flags[i][0] || flags[i][2])
            return 0;
        diff = now - deadline[i];
        if (flags[i][1])
            return !diff[31];
        return flags[i][3];
    endfunction

    // computes the beats one item produces and updates the shadow table
    task automatic predict_dispatcher(input logic [3:0] fn, input logic [3:0] sl,
                                      input logic [2:0] pr, input logic [23:0] per,
                                      input logic [31:0] lim, input logic [31:0] now,
                                      input logic [31:0] t0);
        logic [31:0] pc;
        logic [31:0] us;
        logic [31:0] diff;
        logic [2:0]  p;
        beat_t       b;
        int          n;
        if (fn == FN_REG_PER || fn == FN_REG_EVT) begin
            if (fn == FN_REG_PER && per == 24'd0) begin
                pending_beats.push_back(mk(ST_BAD, 4'd0, 1'b1));
            end
            else if (used >= NSLOT) begin
                pending_beats.push_back(mk(ST_FULL, 4'd0, 1'b1));
            end
            else begin
                p = (pr > NPRIO - 1) ? 3'(NPRIO - 1) : pr;
                flags[used] = {1'b0, p, 3'b000, 1'b1};
                if (fn == FN_REG_PER) begin
                    flags[used][1] = 1'b1;
                    pc = {8'd0, per} * eff_rate();
                    if (pc == 0)
                        pc = 1;
                    period_c[used] = pc;
                    deadline[used] = now + pc;
                end
                limit_us[used] = lim;
                st_runs[used] = 0;
                st_last[used] = 0;
                st_peak[used] = 0;
                st_over[used] = 0;
                st_miss[used] = 0;
                pending_beats.push_back(mk(ST_OK, 4'(used), 1'b1));
                used++;
            end
        end
        else if (fn == FN_DISPATCH) begin
            n = 0;
            for (int q = 0; q < NPRIO; q++)
                for (int i = 0; i < used; i++)
                    if (int'(flags[i][6:4]) == q && slot_due(i, now)) begin
                        pending_beats.push_back(mk(ST_OK, 4'(i), 1'b0));
                        n++;
                    end
            if (n == 0)
                pending_beats.push_back(mk(ST_NONE, 4'd0, 1'b1));
            else
                pending_beats[pending_beats.size() - 1].last = 1'b1;
        end
        else if (fn == FN_CLEAR) begin
            for (int i = 0; i < NSLOT; i++) begin
                st_runs[i] = 0;
                st_last[i] = 0;
                st_peak[i] = 0;
                st_over[i] = 0;
                st_miss[i] = 0;
            end
            pending_beats.push_back(mk(ST_OK, 4'd0, 1'b1));
        end
        else if (fn > FN_CLEAR || int'(sl) >= used) begin
            pending_beats.push_back(mk(ST_BAD, 4'd0, 1'b1));
        end
        else begin
            case (fn)
                FN_SUSPEND: flags[sl][2] = 1'b1;
                FN_RESUME: begin
                    flags[sl][2] = 1'b0;
                    if (flags[sl][1])
                        deadline[sl] = now + period_c[sl];
                end
                FN_RAISE: if (!flags[sl][1]) flags[sl][3] = 1'b1;
                FN_DONE: begin
                    if (stats_on) begin
                        us = (now - t0) / eff_rate();
                        st_runs[sl]++;
                        st_last[sl] = us;
                        if (us > st_peak[sl])
                            st_peak[sl] = us;
                        if (ovr_on && limit_us[sl] > 0 && us > limit_us[sl])
                            st_over[sl]++;
                        if (flags[sl][1] && us > period_c[sl] / eff_rate())
                            st_over[sl]++;
                    end
                    if (flags[sl][1]) begin
                        deadline[sl] = now + period_c[sl];
                        diff = now - deadline[sl];
                        if (!diff[31] && stats_on)
                            st_miss[sl]++;
                    end
                    else begin
                        flags[sl][3] = 1'b0;
                    end
                end
                default: ;
            endcase
            b = mk(ST_OK, sl, 1'b1);
            if (fn == FN_QUERY) begin
                b.runs     = st_runs[sl];
                b.last_us  = st_last[sl];
                b.peak_us  = st_peak[sl];
                b.overruns = st_over[sl];
                b.missed   = st_miss[sl];
            end
            pending_beats.push_back(b);
        end
    endtask

    // called at a rising edge; start stays high when items follow back to back
    task automatic send_item(input logic [3:0] fn, input logic [3:0] sl, input logic [2:0] pr,
                             input logic [23:0] per, input logic [31:0] lim,
                             input logic [31:0] now, input logic [31:0] t0);
        func          <= fn;
        slot_index    <= sl;
        task_priority <= pr;
        task_period   <= per;
        exec_limit    <= lim;
        time_now      <= now;
        run_start     <= t0;
        start         <= 1'b1;
        do @(posedge clk); while (busy);
        predict_dispatcher(fn, sl, pr, per, lim, now, t0);
        if ($urandom_range(99) < gap_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    endtask

    task automatic idle_start();
        start <= 1'b0;
        @(posedge clk);
    endtask

    task automatic write_cfg(input logic [1:0] idx, input logic [7:0] val);
        idle_start();
        wait (pending_beats.size() == 0);
        repeat (SETTLE) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            CFG_STATS: stats_on   = val[0];
            CFG_OVR:   ovr_on     = val[0];
            default:   cyc_per_us = val;
        endcase
    endtask

    task automatic test_registration();
        gap_pct = 0;
        write_cfg(CFG_RATE, 8'd255);
        send_item(FN_REG_PER, 4'd0, 3'd0, 24'hFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'd0);
        send_item(FN_REG_PER, 4'd0, 3'd7, 24'd0, 32'd0, 32'd0, 32'd0);   // zero period refused
        send_item(FN_REG_PER, 4'd0, 3'd7, 24'd3, 32'd0, 32'd100, 32'd0); // priority saturates
        send_item(FN_REG_EVT, 4'd0, 3'd2, 24'd0, 32'd5, 32'd0, 32'd0);
        send_item(FN_REG_EVT, 4'd0, 3'd0, 24'd0, 32'd0, 32'd0, 32'd0);
    endtask

    task automatic test_slot_ops();
        send_item(FN_QUERY, 4'd15, 3'd0, 24'd0, 32'd0, 32'd0, 32'd0);   // unregistered
        send_item(4'd9, 4'd0, 3'd0, 24'd0, 32'd0, 32'd0, 32'd0);
        send_item(4'd15, 4'd0, 3'd0, 24'd0, 32'd0, 32'd0, 32'd0);
        send_item(FN_RAISE, 4'd1, 3'd0, 24'd0, 32'd0, 32'd0, 32'd0);     // periodic: no effect
        send_item(FN_RAISE, 4'd2, 3'd0, 24'd0, 32'd0, 32'd0, 32'd0);
        send_item(FN_SUSPEND, 4'd3, 3'd0, 24'd0, 32'd0, 32'd0, 32'd0);
        send_item(FN_RAISE, 4'd3, 3'd0, 24'd0, 32'd0, 32'd0, 32'd0);
        send_item(FN_DISPATCH, 4'd0, 3'd0, 24'd0, 32'd0, 32'd5000, 32'd0);
        send_item(FN_RESUME, 4'd3, 3'd0, 24'd0, 32'd0, 32'd5000, 32'd0);
        send_item(FN_DISPATCH, 4'd0, 3'd0, 24'd0, 32'd0, 32'd5000, 32'd0);
    endtask

    task automatic test_done_stats();
        // suspended and never dispatched slots still take a done
        send_item(FN_SUSPEND, 4'd0, 3'd0, 24'd0, 32'd0, 32'd0, 32'd0);
        send_item(FN_DONE, 4'd0, 3'd0, 24'd0, 32'd0, 32'hFFFFFFFF, 32'd0);
        send_item(FN_DONE, 4'd1, 3'd0, 24'd0, 32'd0, 32'd20000, 32'd1);
        send_item(FN_DONE, 4'd2, 3'd0, 24'd0, 32'd0, 32'd3000, 32'd10);
        send_item(FN_DONE, 4'd3, 3'd0, 24'd0, 32'd0, 32'd5, 32'hFFFFFFF0); // wraps
        for (int i = 0; i < 4; i++)
            send_item(FN_QUERY, 4'(i), 3'd0, 24'd0, 32'd0, 32'd0, 32'd0);
        send_item(FN_CLEAR, 4'd0, 3'd0, 24'd0, 32'd0, 32'd0, 32'd0);
        send_item(FN_QUERY, 4'd0, 3'd0, 24'd0, 32'd0, 32'd0, 32'd0);
        send_item(FN_RESUME, 4'd0, 3'd0, 24'd0, 32'd0, 32'd0, 32'd0);
        write_cfg(CFG_RATE, 8'd0);   // zero rate acts as one
        send_item(FN_REG_PER, 4'd0, 3'd1, 24'd2, 32'd1, 32'd0, 32'd0);
        send_item(FN_DONE, 4'd4, 3'd0, 24'd0, 32'd0, 32'd9, 32'd0);
        send_item(FN_QUERY, 4'd4, 3'd0, 24'd0, 32'd0, 32'd0, 32'd0);
    endtask

    task automatic random_phase(input int items, input int pct);
        int          r;
        logic [3:0]  sl;
        logic [31:0] lim;
        gap_pct = pct;
        for (int k = 0; k < items; k++) begin
            r  = $urandom_range(99);
            sl = (used > 0) ? 4'($urandom_range(used - 1)) : 4'd0;
            clock_now = clock_now + $urandom_range(0, 400);
            if ($urandom_range(19) == 0)
                clock_now = $urandom;
            if (r < 25) begin
                send_item(FN_DISPATCH, 4'($urandom), 3'($urandom), 24'($urandom), $urandom,
                          clock_now, $urandom);
            end
            else if (r < 50) begin
                lim = eff_rate() * $urandom_range(0, 8);
                send_item(FN_DONE, sl, 3'($urandom), 24'($urandom), $urandom,
                          clock_now, clock_now - $urandom_range(0, 3) * lim);
            end
            else if (r < 60) begin
                send_item(FN_RAISE, sl, 3'($urandom), 24'd0, 32'd0, clock_now, 32'd0);
            end
            else if (r < 70) begin
                send_item($urandom_range(1) ? FN_SUSPEND : FN_RESUME, sl, 3'd0, 24'd0,
                          32'd0, clock_now, 32'd0);
            end
            else if (r < 80) begin
                send_item(FN_QUERY, sl, 3'd0, 24'd0, 32'd0, clock_now, 32'd0);
            end
            else if (r < 86 && used < NSLOT - 2) begin
                send_item(4'($urandom_range(1)), 4'd0, 3'($urandom), 24'($urandom_range(1, 3)),
                          32'($urandom_range(0, 4)), clock_now, 32'd0);
            end
            else if (r < 88) begin
                send_item(FN_CLEAR, 4'd0, 3'd0, 24'd0, 32'd0, clock_now, 32'd0);
            end
            else begin
                send_item(4'($urandom_range(2, 15)), 4'($urandom), 3'($urandom),
                          24'($urandom), $urandom, $urandom, $urandom);
            end
        end
    endtask

    task automatic test_random();
        clock_now = 32'd0;
        write_cfg(CFG_RATE, 8'd1);
        random_phase(16, 0);
        write_cfg(CFG_STATS, 1'b0);
        write_cfg(CFG_OVR, 1'b0);
        random_phase(16, 64);
        write_cfg(CFG_STATS, 1'b1);
        write_cfg(CFG_RATE, 8'd2);
        random_phase(16, 0);
        write_cfg(CFG_OVR, 1'b1);
        write_cfg(CFG_RATE, 8'd1);
        random_phase(16, 31);
    endtask

    task automatic test_full_table();
        gap_pct = 0;
        while (used < NSLOT)
            send_item(FN_REG_EVT, 4'd0, 3'd4, 24'd0, 32'd0, 32'd0, 32'd0);
        send_item(FN_REG_EVT, 4'd0, 3'd0, 24'd0, 32'd0, 32'd0, 32'd0);
        send_item(FN_REG_PER, 4'd0, 3'd0, 24'd1, 32'd0, 32'd0, 32'd0);
        send_item(FN_RAISE, 4'd15, 3'd0, 24'd0, 32'd0, 32'd0, 32'd0);
        send_item(FN_DISPATCH, 4'd0, 3'd0, 24'd0, 32'd0, clock_now, 32'd0);
        idle_start();
    endtask

    initial begin
        errors = 0;
        cycles = 0;
        gap_pct = 0;
        stats_on = 1'b1;
        ovr_on = 1'b1;
        cyc_per_us = 8'd168;
        used = 0;
        for (int i = 0; i < NSLOT; i++)
            flags[i] = '0;
        rst_n = 1'b0;
        start = 1'b0;
        func = '0;
        slot_index = '0;
        task_priority = '0;
        task_period = '0;
        exec_limit = '0;
        time_now = '0;
        run_start = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_registration();
        test_slot_ops();
        test_done_stats();
        test_random();
        test_full_table();
        wait (pending_beats.size() == 0);
        repeat (SETTLE) @(posedge clk);
        if (errors == 0)
            $display("[priority_periodic_task_dispatcher_unit] OK");
        else
            $display("[priority_periodic_task_dispatcher_unit] ERROR");
        $finish;
    end
endmodule
